// ===== sv/symbol_table_insert_search_modify_defines.svh =====
// assertion macros for the symbol table checker
`ifndef SYMBOL_TABLE_INSERT_SEARCH_MODIFY_DEFINES_SVH
`define SYMBOL_TABLE_INSERT_SEARCH_MODIFY_DEFINES_SVH

// check while out of reset
`define SIT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// check at every edge, reset included
`define SIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sit_pkg.sv =====
package sit_pkg;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned AddrW = 16;
  localparam int unsigned ActW  = 2;
  localparam int unsigned StatW = 2;

  typedef enum logic [ActW-1:0] {
    ActInsert = 2'd0,
    ActSearch = 2'd1,
    ActModify = 2'd2
  } action_e;

  typedef enum logic [StatW-1:0] {
    StatOk   = 2'd0,
    StatDup  = 2'd1,
    StatNone = 2'd2,
    StatFull = 2'd3
  } status_e;

endpackage

// ===== sv/sit_store.sv =====
module sit_store import sit_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned LBL_W = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [LBL_W-1:0] rd_label_o,
  input  logic             lbl_we_i,
  input  logic             adr_we_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  logic [LBL_W-1:0] wr_label_i,
  input  logic [AddrW-1:0] wr_addr_i
);

  logic [LBL_W-1:0] label_mem [DEPTH];
  logic [AddrW-1:0] addr_mem  [DEPTH];
  logic [LBL_W-1:0] rd_label_q;

  always_ff @(posedge clk_i) begin
    if (lbl_we_i) begin
      label_mem[wr_idx_i] <= wr_label_i;
    end
    rd_label_q <= label_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i) begin
    if (adr_we_i) begin
      addr_mem[wr_idx_i] <= wr_addr_i;
    end
  end

  assign rd_label_o = rd_label_q;

endmodule

// ===== sv/symbol_table_insert_search_modify.sv =====
// between accept and result valid, n entries are compared (n from 0 to count),
// one label memory read per cycle during the linear scan
// a new item is taken only in idle, and may be taken while the last result waits
// reset: entry count, state, output valid and hit flag clear at once; table contents stay undefined
// and entries at or above the count are never compared
module symbol_table_insert_search_modify import sit_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned LABEL_BYTES   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ActW-1:0]  action_i,
  input  logic [KeyW-1:0]  label_key_i,
  input  logic [AddrW-1:0] address_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             found_o,
  output logic [StatW-1:0] status_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned LblW = LABEL_BYTES * 8;

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StScan    = 2'd1;
  localparam logic [1:0] StResolve = 2'd2;

  logic [1:0]       state_q, state_d;
  action_e          act_q, act_d;
  logic [LblW-1:0]  key_q, key_d;
  logic [AddrW-1:0] adr_q, adr_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  status_e          status_q, status_d;

  logic [IdxW-1:0]  rd_addr;
  logic [LblW-1:0]  rd_label;
  logic             lbl_we, adr_we;
  logic [IdxW-1:0]  wr_idx;
  logic             in_acc, out_free, is_full, last_entry, match;

  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_full    = (count_q == CntW'(TABLE_ENTRIES));
  assign match      = (rd_label == key_q);
  assign last_entry = ((CntW'(rd_idx_q) + CntW'(1)) == count_q);
  assign rd_addr    = (state_q == StIdle) ? '0 : (rd_idx_q + IdxW'(1));

  sit_store #(
    .DEPTH (TABLE_ENTRIES),
    .LBL_W (LblW),
    .IDX_W (IdxW)
  ) u_store (
    .clk_i      (clk_i),
    .rd_idx_i   (rd_addr),
    .rd_label_o (rd_label),
    .lbl_we_i   (lbl_we),
    .adr_we_i   (adr_we),
    .wr_idx_i   (wr_idx),
    .wr_label_i (key_q),
    .wr_addr_i  (adr_q)
  );

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    adr_d       = adr_q;
    rd_idx_d    = rd_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    status_d    = status_q;
    lbl_we      = 1'b0;
    adr_we      = 1'b0;
    wr_idx      = count_q[IdxW-1:0];

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          act_d    = action_e'(action_i);
          key_d    = label_key_i[LblW-1:0];
          adr_d    = address_value_i;
          rd_idx_d = '0;
          hit_d    = 1'b0;
          state_d  = (count_q == '0) ? StResolve : StScan;
        end
      end
      StScan: begin
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_idx_q;
          state_d   = StResolve;
        end else if (last_entry) begin
          state_d = StResolve;
        end else begin
          rd_idx_d = rd_idx_q + IdxW'(1);
        end
      end
      StResolve: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = hit_q;
          status_d    = StatOk;
          state_d     = StIdle;
          case (act_q)
            ActInsert: begin
              if (hit_q) begin
                status_d = StatDup;
              end else if (is_full) begin
                status_d = StatFull;
              end else begin
                lbl_we  = 1'b1;
                adr_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            ActModify: begin
              if (hit_q) begin
                adr_we = 1'b1;
                wr_idx = hit_idx_q;
              end else begin
                status_d = StatNone;
              end
            end
            default: begin
              status_d = StatOk;
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    key_q     <= key_d;
    adr_q     <= adr_d;
    rd_idx_q  <= rd_idx_d;
    hit_idx_q <= hit_idx_d;
    found_q   <= found_d;
    status_q  <= status_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign status_o    = status_q;

endmodule

// ===== sv/sit_checker.sv =====
`include "symbol_table_insert_search_modify_defines.svh"

module sit_checker import sit_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             found_o,
  input logic [StatW-1:0] status_o
);

  `SIT_ASSERT_ALWAYS(a_reset_no_item, clk_i, !rst_ni |=> !out_valid_o,
    "item shown in reset")
  `SIT_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(found_o),
    "stalled item dropped or changed")
  `SIT_ASSERT(a_found_status, clk_i, rst_ni,
    out_valid_o && found_o |-> status_o != StatNone && status_o != StatFull,
    "found item with miss status")
  `SIT_ASSERT(a_dup_found, clk_i, rst_ni, out_valid_o && status_o == StatDup |-> found_o,
    "duplicate without hit")
  `SIT_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o,
    "second item taken during scan")

endmodule

bind symbol_table_insert_search_modify sit_checker u_sit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .found_o     (found_o),
  .status_o    (status_o)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import sit_pkg::*;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned LabelBytes   = 8;
  localparam logic [KeyW-1:0] LabelMask =
    (LabelBytes >= 8) ? {KeyW{1'b1}} : ((64'd1 << (LabelBytes * 8)) - 64'd1);
  localparam logic [ActW-1:0] ActSpare = 2'd3;
  localparam int IdlePct = 13;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] addr;
    logic             drain;
  } request_t;

  typedef struct packed {
    logic    found;
    status_e status;
  } reply_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ActW-1:0]  action = ActSearch;
  logic [KeyW-1:0]  label_key = '0;
  logic [AddrW-1:0] address_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             found;
  logic [StatW-1:0] status;

  request_t request_q[$];
  reply_t   due_replies[$];
  logic [KeyW-1:0] known_keys[$];

  logic [KeyW-1:0]  sym_labels[TableEntries];
  logic [AddrW-1:0] sym_addrs[TableEntries];
  int unsigned      sym_count = 0;

  int       taken_cnt = 0;
  int       error_cnt = 0;
  logic     req_taken = 1'b0;
  request_t next_req;
  reply_t   got_reply;

  wire steady_run = (taken_cnt >= 320) && (taken_cnt < 450);

  symbol_table_insert_search_modify #(
    .TABLE_ENTRIES(TableEntries),
    .LABEL_BYTES  (LabelBytes)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .label_key_i    (label_key),
    .address_value_i(address_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .found_o        (found),
    .status_o       (status)
  );

  always #10 clk_i = ~clk_i;

  // symbol table predictor, first match wins
  function automatic reply_t apply_request(input logic [ActW-1:0] act,
                                           input logic [KeyW-1:0] key_in,
                                           input logic [AddrW-1:0] addr);
    reply_t          r;
    int              hit;
    logic [KeyW-1:0] key;
    key = key_in & LabelMask;
    hit = -1;
    for (int i = 0; i < sym_count; i++) begin
      if (hit < 0 && sym_labels[i] == key) hit = i;
    end
    r.found  = (hit >= 0);
    r.status = StatOk;
    case (act)
      ActInsert: begin
        if (hit >= 0) begin
          r.status = StatDup;
        end else if (sym_count >= TableEntries) begin
          r.status = StatFull;
        end else begin
          sym_labels[sym_count] = key;
          sym_addrs[sym_count]  = addr;
          sym_count++;
        end
      end
      ActModify: begin
        if (hit < 0) r.status = StatNone;
        else sym_addrs[hit] = addr;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic key_known(input logic [KeyW-1:0] key);
    foreach (known_keys[i]) begin
      if (known_keys[i] == (key & LabelMask)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [KeyW-1:0] any_known();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // random label not in the table, sometimes a short zero-padded one
  function automatic logic [KeyW-1:0] fresh_key();
    logic [KeyW-1:0] k;
    int              nbytes;
    do begin
      k = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
        nbytes = $urandom_range(1, 8);
        if (nbytes < 8) k = k & ((64'd1 << (nbytes * 8)) - 64'd1);
      end
      k = k & LabelMask;
    end while (key_known(k));
    return k;
  endfunction

  function automatic void add_request(input logic [ActW-1:0] act, input logic [KeyW-1:0] key,
                                      input logic [AddrW-1:0] addr, input logic drain);
    request_t r;
    r.action = act;
    r.key    = key;
    r.addr   = addr;
    r.drain  = drain;
    request_q.push_back(r);
    // track table contents so searches and modifies can aim at stored labels
    if (act == ActInsert && !key_known(key) && known_keys.size() < TableEntries)
      known_keys.push_back(key & LabelMask);
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || req_taken) begin
        if (request_q.size() != 0 && !(request_q[0].drain && due_replies.size() != 0) &&
            (steady_run || $urandom_range(0, 99) >= IdlePct)) begin
          next_req = request_q.pop_front();
          in_valid      <= 1'b1;
          action        <= next_req.action;
          label_key     <= next_req.key;
          address_value <= next_req.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !steady_run && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("unexpected result: found=%0d status=%0d", found, status);
        end else begin
          got_reply = due_replies.pop_front();
          if (found !== got_reply.found || status !== got_reply.status) begin
            error_cnt++;
            if (error_cnt <= 10)
              $display("mismatch: expected found=%0d status=%0d, got found=%0d status=%0d",
                       got_reply.found, got_reply.status, found, status);
          end
        end
      end
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        due_replies.push_back(apply_request(action, label_key, address_value));
        taken_cnt++;
      end
    end
  end

  initial begin
    int              pick;
    logic [KeyW-1:0] k;

    // directed items
    add_request(ActSearch, 64'd0, 16'h0000, 1'b0);
    add_request(ActModify, 64'd0, 16'h1111, 1'b0);
    add_request(ActSpare, {KeyW{1'b1}}, 16'hffff, 1'b0);
    add_request(ActInsert, 64'd0, 16'h0000, 1'b0);
    add_request(ActInsert, {KeyW{1'b1}}, 16'hffff, 1'b0);
    add_request(ActInsert, 64'd0, 16'hffff, 1'b0);
    add_request(ActSearch, {KeyW{1'b1}}, 16'h0000, 1'b0);
    add_request(ActSearch, 64'd0, 16'hffff, 1'b0);
    add_request(ActModify, {KeyW{1'b1}}, 16'h0000, 1'b0);
    add_request(ActModify, 64'd0, 16'hffff, 1'b0);
    add_request(ActSearch, 64'd1, 16'h0000, 1'b0);
    add_request(ActSearch, ~64'd1, 16'h0000, 1'b0);
    add_request(ActInsert, 64'h8000_0000_0000_0000, 16'h1234, 1'b0);
    add_request(ActSpare, 64'd0, 16'h5555, 1'b0);
    add_request(ActSearch, 64'h0000_0001_0000_0000, 16'haaaa, 1'b0);
    add_request(ActInsert, 64'h0000_0000_0000_0041, 16'h8000, 1'b0);
    add_request(ActSearch, 64'h0000_0000_0000_4100, 16'h0001, 1'b0);
    add_request(ActModify, 64'h8000_0000_0000_0000, 16'h0001, 1'b0);
    add_request(ActInsert, 64'h8000_0000_0000_0000, 16'h7fff, 1'b0);

    // random items: table fills, then stays full
    for (int i = 0; i < 600; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        k = fresh_key();
        add_request(ActInsert, k, 16'($urandom_range(0, 65535)), i == 0 || i == 300 || i == 500);
      end else begin
        if (pick < 33) add_request(ActInsert, any_known(), 16'($urandom_range(0, 65535)), 1'b0);
        else if (pick < 50) add_request(ActSearch, any_known(), 16'($urandom), 1'b0);
        else if (pick < 60) add_request(ActSearch, fresh_key(), 16'($urandom), 1'b0);
        else if (pick < 72) add_request(ActModify, any_known(), 16'($urandom), 1'b0);
        else if (pick < 80) add_request(ActModify, fresh_key(), 16'($urandom), 1'b0);
        else if (pick < 86)
          add_request(ActSpare, $urandom_range(0, 1) ? any_known() : fresh_key(),
                      16'($urandom), 1'b0);
        else begin
          // near miss: stored label with one bit flipped
          k = any_known() ^ (64'd1 << $urandom_range(0, KeyW - 1));
          add_request(2'($urandom_range(0, 3)), k, 16'($urandom), 1'b0);
        end
        if (i == 0 || i == 300 || i == 500) request_q[request_q.size() - 1].drain = 1'b1;
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (request_q.size() != 0 || in_valid) @(posedge clk_i);
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
